// ----- design/isp_pkg.sv -----
// -----------------------------------------------------------------------------
// isp_pkg: shared types and constants of the ILDA stream parser
// Beat structs for both channels, result kind codes and record layout helpers.
// -----------------------------------------------------------------------------
package isp_pkg;

	// Result kind codes
	localparam logic [2:0] KIND_POINT   = 3'd0;
	localparam logic [2:0] KIND_PALETTE = 3'd1;
	localparam logic [2:0] KIND_HEADER  = 3'd2;
	localparam logic [2:0] KIND_END     = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	// Record format codes of the header format byte
	localparam logic [2:0] FMT_3D_INDEXED = 3'd0;
	localparam logic [2:0] FMT_2D_INDEXED = 3'd1;
	localparam logic [2:0] FMT_PALETTE    = 3'd2;
	localparam logic [2:0] FMT_3D_TRUE    = 3'd4;
	localparam logic [2:0] FMT_2D_TRUE    = 3'd5;

	// Format code kept for any unsupported header format byte
	localparam logic [2:0] BAD_FORMAT = 3'd3;

	// Largest record (format 4); all but its final byte are buffered
	localparam int unsigned REC_BUF_BYTES = 10;
	localparam int unsigned REC_STORE     = REC_BUF_BYTES - 1;

	// Header byte positions
	localparam logic [4:0] HPOS_FORMAT = 5'd7;
	localparam logic [4:0] HPOS_CNT_HI = 5'd24;
	localparam logic [4:0] HPOS_CNT_LO = 5'd25;
	localparam logic [4:0] HPOS_NUM_HI = 5'd26;
	localparam logic [4:0] HPOS_NUM_LO = 5'd27;
	localparam logic [4:0] HPOS_LAST   = 5'd31;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]         item_kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic               last_point;
		logic               blanking;
		logic [7:0]         color_index;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [2:0]         record_format;
		logic [15:0]        header_number;
	} out_beat_t;

	// Expected character of the "ILDA" tag at header positions 0..3
	function automatic logic [7:0] tag_char(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0:    c = 8'h49;
			2'd1:    c = 8'h4C;
			2'd2:    c = 8'h44;
			default: c = 8'h41;
		endcase
		return c;
	endfunction

	// Bytes per record for a format code
	function automatic logic [3:0] record_size(input logic [2:0] fmt);
		logic [3:0] s;
		case (fmt)
			FMT_2D_INDEXED: s = 4'd6;
			FMT_PALETTE:    s = 4'd3;
			FMT_3D_TRUE:    s = 4'd10;
			default:        s = 4'd8;
		endcase
		return s;
	endfunction

	// Result with every field cleared except kind, format and number
	function automatic out_beat_t make_result(input logic [2:0] kind, input logic [2:0] fmt,
			input logic [15:0] num);
		out_beat_t r;
		r = '0;
		r.item_kind     = kind;
		r.record_format = fmt;
		r.header_number = num;
		return r;
	endfunction

endpackage

// ----- design/isp_parser.sv -----
// -----------------------------------------------------------------------------
// isp_parser: header and record parsing state with combinational decode
// Updates the parse state on each accepted byte and forms up to two results.
// -----------------------------------------------------------------------------
module isp_parser import isp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  in_beat_t   beat,
	output logic [1:0] res_cnt,
	output out_beat_t  res0,
	output out_beat_t  res1
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_RECORDS = 2'd1;
	localparam logic [1:0] PH_DONE    = 2'd2;

	logic [1:0]  phase_q, phase_d;
	logic [4:0]  hpos_q, hpos_d;
	logic [3:0]  rpos_q, rpos_d;
	logic [15:0] left_q, left_d;
	logic [2:0]  fmt_q, fmt_d;
	logic        tag_q, tag_d;
	logic [15:0] frame_q, frame_d;
	logic [7:0]  rec_q [REC_STORE];

	logic        rec_we;
	logic [3:0]  rec_pos;
	logic [3:0]  rec_size;
	logic        rec_done;
	logic [7:0]  b [REC_BUF_BYTES];
	logic        finished;
	out_beat_t   pt;
	out_beat_t   tail;

	// Clamp the record position and detect the final byte of a record
	always_comb begin
		rec_size = record_size(fmt_q);
		rec_pos  = (rpos_q >= rec_size) ? rec_size - 4'd1 : rpos_q;
		rec_done = ({1'b0, rec_pos} + 5'd1) >= {1'b0, rec_size};
	end

	// Assemble the record bytes, current byte at the current record position
	always_comb begin
		for (int i = 0; i < REC_STORE; i++) begin
			if (4'(i) < rec_pos)
				b[i] = rec_q[i];
			else if (4'(i) == rec_pos)
				b[i] = beat.data_byte;
			else
				b[i] = 8'h00;
		end
		b[REC_STORE] = (rec_pos == 4'(REC_STORE)) ? beat.data_byte : 8'h00;
	end

	// Decode one record by format
	always_comb begin
		pt = make_result(KIND_POINT, fmt_q, frame_q);
		pt.pos_x = {b[0], b[1]};
		pt.pos_y = {b[2], b[3]};
		case (fmt_q)
			FMT_2D_INDEXED: begin
				pt.last_point  = b[4][7];
				pt.blanking    = b[4][6];
				pt.color_index = b[5];
			end
			FMT_PALETTE: begin
				pt.item_kind = KIND_PALETTE;
				pt.pos_x     = '0;
				pt.pos_y     = '0;
				pt.red       = b[0];
				pt.green     = b[1];
				pt.blue      = b[2];
			end
			FMT_3D_TRUE: begin
				pt.pos_z      = {b[4], b[5]};
				pt.last_point = b[6][7];
				pt.blanking   = b[6][6];
				pt.red        = b[9];
				pt.green      = b[8];
				pt.blue       = b[7];
			end
			FMT_2D_TRUE: begin
				pt.last_point = b[4][7];
				pt.blanking   = b[4][6];
				pt.red        = b[7];
				pt.green      = b[6];
				pt.blue       = b[5];
			end
			default: begin
				pt.pos_z       = {b[4], b[5]};
				pt.last_point  = b[6][7];
				pt.blanking    = b[6][6];
				pt.color_index = b[7];
			end
		endcase
	end

	// Next state and results for the byte at the input
	always_comb begin
		phase_d  = phase_q;
		hpos_d   = hpos_q;
		rpos_d   = rpos_q;
		left_d   = left_q;
		fmt_d    = fmt_q;
		tag_d    = tag_q;
		frame_d  = frame_q;
		rec_we   = 1'b0;
		finished = 1'b0;
		res_cnt  = 2'd0;
		res0     = '0;
		res1     = '0;
		tail     = '0;

		unique case (phase_q)
			PH_HEADER: begin
				if (hpos_q < 5'd4 && beat.data_byte != tag_char(hpos_q[1:0]))
					tag_d = 1'b0;
				if (hpos_q == HPOS_FORMAT)
					fmt_d = (beat.data_byte <= 8'd5) ? beat.data_byte[2:0] : BAD_FORMAT;
				if (hpos_q == HPOS_CNT_HI)
					left_d = {beat.data_byte, 8'h00};
				if (hpos_q == HPOS_CNT_LO)
					left_d = {left_q[15:8], beat.data_byte};
				if (hpos_q == HPOS_NUM_HI)
					frame_d = {beat.data_byte, 8'h00};
				if (hpos_q == HPOS_NUM_LO)
					frame_d = {frame_q[15:8], beat.data_byte};
				if (hpos_q == HPOS_LAST) begin
					hpos_d  = 5'd0;
					tag_d   = 1'b1;
					res_cnt = 2'd1;
					if (!tag_q || fmt_q == BAD_FORMAT) begin
						res0     = make_result(KIND_ERROR, fmt_q, 16'd0);
						phase_d  = PH_DONE;
						finished = 1'b1;
					end else if (left_q == 16'd0) begin
						res0     = make_result(KIND_END, fmt_q, 16'd0);
						phase_d  = PH_DONE;
						finished = 1'b1;
					end else begin
						res0    = make_result(KIND_HEADER, fmt_q, left_q);
						phase_d = PH_RECORDS;
						rpos_d  = 4'd0;
					end
				end else begin
					hpos_d = hpos_q + 5'd1;
				end
			end
			PH_RECORDS: begin
				if (rec_done) begin
					res0    = pt;
					res_cnt = 2'd1;
					rpos_d  = 4'd0;
					left_d  = left_q - 16'd1;
					if (left_q == 16'd1) begin
						phase_d = PH_HEADER;
						hpos_d  = 5'd0;
						tag_d   = 1'b1;
					end
				end else begin
					rec_we = 1'b1;
					rpos_d = rec_pos + 4'd1;
				end
			end
			default: begin
				finished = 1'b1;
			end
		endcase

		// End of input: report and start over
		if (beat.last_byte) begin
			if (!finished) begin
				if (phase_d == PH_HEADER && hpos_d == 5'd0)
					tail = make_result(KIND_END, fmt_d, 16'd0);
				else
					tail = make_result(KIND_ERROR, fmt_d, 16'd0);
				if (res_cnt == 2'd0)
					res0 = tail;
				else
					res1 = tail;
				res_cnt = res_cnt + 2'd1;
			end
			phase_d = PH_HEADER;
			hpos_d  = 5'd0;
			rpos_d  = 4'd0;
			left_d  = 16'd0;
			fmt_d   = FMT_3D_INDEXED;
			tag_d   = 1'b1;
			frame_d = 16'd0;
		end
	end

	// Advance parse state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hpos_q  <= 5'd0;
			rpos_q  <= 4'd0;
			left_q  <= 16'd0;
			fmt_q   <= FMT_3D_INDEXED;
			tag_q   <= 1'b1;
			frame_q <= 16'd0;
		end else if (take) begin
			phase_q <= phase_d;
			hpos_q  <= hpos_d;
			rpos_q  <= rpos_d;
			left_q  <= left_d;
			fmt_q   <= fmt_d;
			tag_q   <= tag_d;
			frame_q <= frame_d;
		end
	end

	// Hold record bytes until the record completes
	always_ff @(posedge clk) begin
		if (take && rec_we)
			rec_q[rec_pos] <= beat.data_byte;
	end

endmodule

// ----- design/isp_result_queue.sv -----
// -----------------------------------------------------------------------------
// isp_result_queue: small result FIFO between the parser and the output port
// Takes up to two results per cycle; pops one per cycle when out_ready is high.
// -----------------------------------------------------------------------------
module isp_result_queue import isp_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  out_beat_t  push0,
	input  out_beat_t  push1,
	output logic       room,
	output logic       out_valid,
	input  logic       out_ready,
	output out_beat_t  out_beat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	out_beat_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q, wr_nxt;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_nxt    = wrap_inc(wr_q);
	assign out_valid = (cnt_q != '0);
	assign out_beat  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= CW'(DEPTH - 2));

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_q] <= push0;
		if (push_cnt == 2'd2)
			mem_q[wr_nxt] <= push1;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_cnt == 2'd1)
				wr_q <= wr_nxt;
			else if (push_cnt == 2'd2)
				wr_q <= wrap_inc(wr_nxt);
			if (pop)
				rd_q <= wrap_inc(rd_q);
			cnt_q <= cnt_q + CW'(push_cnt) - CW'(pop);
		end
	end

endmodule

// ----- design/ilda_stream_parser.sv -----
// -----------------------------------------------------------------------------
// ilda_stream_parser: ILDA image byte stream parser
// Decodes headers and point or palette records of an ILDA byte stream.
// -----------------------------------------------------------------------------
// One byte is taken per cycle while in_ready is high and is fully parsed in
// the cycle it is accepted; the parse state registers and a short result
// queue (QUEUE_DEPTH entries) are the only storage on the path. A byte
// yields zero, one or two results, which reach the output one per cycle while
// out_ready is high; in_ready drops only while the queue has fewer than two
// free entries, so with out_ready held high the block sustains one byte per
// clock. Results enter the queue on the edge that takes their byte. A byte
// flagged last_byte resets the parser, so the next byte starts a new file.
module ilda_stream_parser import isp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_beat,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_beat
);

	logic       take;
	logic [1:0] res_cnt, push_cnt;
	out_beat_t  res0, res1;

	assign take     = in_valid && in_ready;
	assign push_cnt = take ? res_cnt : 2'd0;

	// Parse each accepted beat
	isp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.beat    (in_beat),
		.res_cnt (res_cnt),
		.res0    (res0),
		.res1    (res1)
	);

	// Buffer results toward the output
	isp_result_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (res0),
		.push1     (res1),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_beat  (out_beat)
	);

endmodule
